FILE: rtl/lbor_pkg.sv
// ----------------------------------------------------------------------------
// lbor_pkg
// Shared types and codes of the layered box overlap registry.
// ----------------------------------------------------------------------------
package lbor_pkg;

    // Operation codes carried in the opcode field of an input item.
    localparam logic [2:0] OP_ADD_DYN   = 3'd0;
    localparam logic [2:0] OP_ADD_STA   = 3'd1;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd2;
    localparam logic [2:0] OP_CLEAR_DYN = 3'd3;
    localparam logic [2:0] OP_QUERY     = 3'd4;

    // One stored box as it sits in the table memory, x in the lowest bits.
    typedef struct packed {
        logic        [15:0] id;
        logic        [15:0] h;
        logic        [15:0] w;
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Query box with its edges worked out once, wide enough to avoid wrap.
    typedef struct packed {
        logic        [15:0] id;
        logic signed [17:0] left;
        logic signed [17:0] top;
        logic signed [17:0] right;
        logic signed [17:0] bottom;
    } t_qbox;

endpackage

FILE: rtl/lbor_ram.sv
// ----------------------------------------------------------------------------
// lbor_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lbor_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/lbor_overlap.sv
// ----------------------------------------------------------------------------
// lbor_overlap
// Strict overlap test of the query box against one stored box, skipping a
// stored box that carries the query's own id.
// ----------------------------------------------------------------------------
module lbor_overlap
    import lbor_pkg::*;
(
    input  t_qbox  i_query,
    input  t_entry i_entry,
    output logic   o_hit
);

    logic signed [17:0] ox;
    logic signed [17:0] oy;
    logic signed [17:0] ox2;
    logic signed [17:0] oy2;

    always_comb begin
        ox  = 18'(i_entry.x);
        oy  = 18'(i_entry.y);
        ox2 = ox + $signed({2'b00, i_entry.w});
        oy2 = oy + $signed({2'b00, i_entry.h});
        o_hit = (i_entry.id != i_query.id) &&
                (i_query.left < ox2) && (i_query.right > ox) &&
                (i_query.top < oy2) && (i_query.bottom > oy);
    end

endmodule

FILE: rtl/layered_box_overlap_registry.sv
// ----------------------------------------------------------------------------
// layered_box_overlap_registry
// Axis-aligned box table per collision channel with insert, clear and
// overlap query operations, held in one table memory.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                   Payload
// s (item)  in         i_s_tvalid / o_s_tready     i_s_tdata  (96 bits)
// m (item)  out        o_m_tvalid / i_m_tready     o_m_tdata  (8 bits)
//
// Items are taken one at a time: the block is ready for the next item only
// once the last one is through, and its result becomes valid in the same
// cycle as the block is ready again. A clear, an ignored opcode, a dynamic
// insert or a dropped insert passes through the execute and done states. A
// static insert moves each dynamic box of its channel up one slot (memory
// read, then write back), then writes the new box above the static boxes. A
// query reads one stored box per cycle from the table memory and steps
// through each of the first eight channels besides, whether its mask bit is
// set or not. Reset clears the sequencer and the per-channel counts; the
// table memory needs no clearing pass. A stalled result waits in the output
// register while the next item is accepted; that item's result then waits
// until the register frees.
//
module layered_box_overlap_registry
    import lbor_pkg::*;
#(
    parameter int CHANNELS          = 8,
    parameter int SLOTS_PER_CHANNEL = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item, from bit 0 up: opcode[3], channel[3], query_mask[8],
    // box_id[16], box_x[16], box_y[16], box_w[16], box_h[16], zero fill[2].
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,
    // Result item, from bit 0 up: hit[1], status[1], zero fill[6].
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata
);

    // Sizes that follow from the parameters.
    localparam int DEPTH  = CHANNELS * SLOTS_PER_CHANNEL;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W  = $clog2(SLOTS_PER_CHANNEL + 1);
    // A query mask has eight bits, so at most eight channels are walked.
    localparam int NQ     = (CHANNELS < 8) ? CHANNELS : 8;

    localparam logic [ADDR_W-1:0] SLOTS_A = ADDR_W'(SLOTS_PER_CHANNEL);
    localparam logic [CNT_W-1:0]  SLOTS_C = CNT_W'(SLOTS_PER_CHANNEL);
    localparam logic [4:0]        CHAN_C  = 5'(CHANNELS);
    localparam logic [2:0]        LAST_QCH = 3'(NQ - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_EXEC     = 3'd1;
    localparam logic [2:0] S_SHIFT_RD = 3'd2;
    localparam logic [2:0] S_SHIFT_WR = 3'd3;
    localparam logic [2:0] S_PLACE    = 3'd4;
    localparam logic [2:0] S_QUERY    = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]        r_state;

    // Captured input item.
    logic [2:0]        r_op;
    logic [2:0]        r_ch;
    logic [7:0]        r_mask;
    t_entry            r_new;
    t_qbox             r_q;
    logic [ADDR_W-1:0] r_base;

    // Per-channel fill and static counts, kept in flip-flops.
    logic [CNT_W-1:0]  r_cnt  [CHANNELS];
    logic [CNT_W-1:0]  r_scnt [CHANNELS];

    // Static insert shift pointer and query walk position.
    logic [CNT_W-1:0]  r_idx;
    logic [2:0]        r_qch;
    logic [CNT_W-1:0]  r_qi;
    logic              r_rv;

    // Result being built and the output register.
    logic              r_hit;
    logic              r_status;
    logic              r_ovld;
    logic              r_ohit;
    logic              r_ostat;

    // Table memory ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    t_entry            ram_rdata;

    logic              cmp_hit;
    logic              s_accept;
    logic [CNT_W-1:0]  ch_cnt;
    logic [CNT_W-1:0]  ch_scnt;
    logic              ch_ok;
    logic [CNT_W-1:0]  q_cnt;
    logic              q_sel;
    logic              q_read;

    logic signed [17:0] in_x;
    logic signed [17:0] in_y;

    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {6'b000000, r_ostat, r_ohit};

    // Counts of the insert channel; the channel check gates any stray read.
    assign ch_cnt  = r_cnt[CH_W'(r_ch)];
    assign ch_scnt = r_scnt[CH_W'(r_ch)];
    assign ch_ok   = ({2'b00, r_ch} < CHAN_C) && (ch_cnt < SLOTS_C);

    // Query walk: read the next box of the current channel while any remain.
    assign q_cnt  = r_cnt[CH_W'(r_qch)];
    assign q_sel  = r_mask[r_qch];
    assign q_read = q_sel && (r_qi < q_cnt);

    assign in_x = 18'($signed(i_s_tdata[45:30]));
    assign in_y = 18'($signed(i_s_tdata[61:46]));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_base;
        ram_wdata = r_new;
        ram_re    = 1'b0;
        ram_raddr = r_base;
        case (r_state)
            S_EXEC: begin
                if (r_op == OP_ADD_DYN && ch_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_base + ADDR_W'(ch_cnt);
                end
            end
            S_SHIFT_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_base + ADDR_W'(r_idx - CNT_W'(1));
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_base + ADDR_W'(r_idx);
                ram_wdata = ram_rdata;
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = r_base + ADDR_W'(ch_scnt);
            end
            S_QUERY: begin
                ram_re    = q_read;
                ram_raddr = ADDR_W'(r_qch) * SLOTS_A + ADDR_W'(r_qi);
            end
            default: begin
            end
        endcase
    end

    lbor_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lbor_overlap u_overlap (
        .i_query (r_q),
        .i_entry (ram_rdata),
        .o_hit   (cmp_hit)
    );

    // Payload capture at acceptance; no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op      <= i_s_tdata[2:0];
            r_ch      <= i_s_tdata[5:3];
            r_mask    <= i_s_tdata[13:6];
            r_new.id  <= i_s_tdata[29:14];
            r_new.x   <= i_s_tdata[45:30];
            r_new.y   <= i_s_tdata[61:46];
            r_new.w   <= i_s_tdata[77:62];
            r_new.h   <= i_s_tdata[93:78];
            r_q.id    <= i_s_tdata[29:14];
            r_q.left  <= in_x;
            r_q.top   <= in_y;
            r_q.right  <= in_x + $signed({2'b00, i_s_tdata[77:62]});
            r_q.bottom <= in_y + $signed({2'b00, i_s_tdata[93:78]});
            r_base    <= ADDR_W'(i_s_tdata[5:3]) * SLOTS_A;
        end
    end

    // Sequencer, counts and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rv     <= 1'b0;
            r_hit    <= 1'b0;
            r_status <= 1'b0;
            r_ovld   <= 1'b0;
            r_ohit   <= 1'b0;
            r_ostat  <= 1'b0;
            r_idx    <= '0;
            r_qch    <= '0;
            r_qi     <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_cnt[c]  <= '0;
                r_scnt[c] <= '0;
            end
        end else begin
            if (r_ovld && i_m_tready) begin
                r_ovld <= 1'b0;
            end

            // Compare stage of the query: one stored box per valid read.
            r_rv <= 1'b0;
            if (r_rv && cmp_hit) begin
                r_hit <= 1'b1;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_hit    <= 1'b0;
                        r_status <= 1'b0;
                        r_state  <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    case (r_op)
                        OP_ADD_DYN: begin
                            if (ch_ok) begin
                                r_cnt[CH_W'(r_ch)] <= ch_cnt + CNT_W'(1);
                            end else begin
                                r_status <= 1'b1;
                            end
                        end
                        OP_ADD_STA: begin
                            if (!ch_ok) begin
                                r_status <= 1'b1;
                            end else if (ch_cnt > ch_scnt) begin
                                r_idx   <= ch_cnt;
                                r_state <= S_SHIFT_RD;
                            end else begin
                                r_state <= S_PLACE;
                            end
                        end
                        OP_CLEAR_ALL: begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                r_cnt[c]  <= '0;
                                r_scnt[c] <= '0;
                            end
                        end
                        OP_CLEAR_DYN: begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                r_cnt[c] <= r_scnt[c];
                            end
                        end
                        OP_QUERY: begin
                            r_qch   <= '0;
                            r_qi    <= '0;
                            r_state <= S_QUERY;
                        end
                        default: begin
                        end
                    endcase
                end
                S_SHIFT_RD: begin
                    r_state <= S_SHIFT_WR;
                end
                S_SHIFT_WR: begin
                    // The box read last cycle is written one slot higher.
                    r_idx <= r_idx - CNT_W'(1);
                    if ((r_idx - CNT_W'(1)) > ch_scnt) begin
                        r_state <= S_SHIFT_RD;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_cnt[CH_W'(r_ch)]  <= ch_cnt + CNT_W'(1);
                    r_scnt[CH_W'(r_ch)] <= ch_scnt + CNT_W'(1);
                    r_state             <= S_DONE;
                end
                S_QUERY: begin
                    if (q_read) begin
                        r_rv <= 1'b1;
                        r_qi <= r_qi + CNT_W'(1);
                    end else begin
                        r_qi <= '0;
                        if (r_qch == LAST_QCH) begin
                            r_state <= S_DONE;
                        end else begin
                            r_qch <= r_qch + 3'd1;
                        end
                    end
                end
                S_DONE: begin
                    // Hand the result over once the output register is free.
                    if (!r_ovld || i_m_tready) begin
                        r_ovld  <= 1'b1;
                        r_ohit  <= r_hit;
                        r_ostat <= r_status;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // No memory read may still be in flight once the block takes a new item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_rv)
        else $error("query read still in flight while idle");

    // A hit is only ever found while a query walks the table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hit) |-> ($past(r_state) == S_QUERY || $past(r_state) == S_DONE))
        else $error("hit raised outside a query");

    // A result never reports a hit together with a dropped insert.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("hit and dropped status together");

    // The static part of channel zero never exceeds its fill, nor the fill its slots.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_scnt[0] <= r_cnt[0]) && (r_cnt[0] <= SLOTS_C))
        else $error("channel counts out of order");

endmodule
